@@ hdl/sjf_pkg.sv @@
// shared constants and types of the shortest-job-first scheduler
package sjf_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 9;

	localparam int QIDX_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int OP_W       = 1;
	localparam int ID_PORT_W  = 9;
	localparam int DUR_W      = 10;
	localparam int TIME_W     = 32;
	localparam int SUM_W      = 48;
	localparam int DONE_W     = 16;
	localparam int QCNT_OUT_W = 5;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_ARRIVE = 1'b0;
	localparam logic [OP_W-1:0] OP_TICK   = 1'b1;

	typedef struct packed {
		logic               tick;
		logic [ID_BITS-1:0] id;
		logic [DUR_W-1:0]   dur;
	} cmd_t;

	// field order gives the dispatch priority: duration, then arrival, then id
	typedef struct packed {
		logic [DUR_W-1:0]   dur;
		logic [TIME_W-1:0]  arr;
		logic [ID_BITS-1:0] id;
	} key_t;

endpackage

@@ hdl/sjf_job_scheduler.sv @@
// top level of the shortest-job-first scheduler
//
//  channel  handshake            payload
//  in       in_valid / in_stall   op, job_id, duration
//  out      out_valid / out_stall arrival_dropped .. queue_count
//
// an item passes a two-entry command queue, then the back end handles an arrival or a
// tick that dispatches nothing straight from idle, and a tick that dispatches through
// the scan that visits one wait slot per cycle
// reset is immediate: no clearing pass, slot contents are gated by their valid bits
// the front keeps taking items while a result is stalled, until its queue fills
module sjf_job_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [sjf_pkg::OP_W-1:0]        op,
	input  logic [sjf_pkg::ID_PORT_W-1:0]   job_id,
	input  logic [sjf_pkg::DUR_W-1:0]       duration,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            arrival_dropped,
	output logic                            completed_valid,
	output logic [sjf_pkg::ID_PORT_W-1:0]   completed_id,
	output logic [sjf_pkg::TIME_W-1:0]      turnaround,
	output logic                            dispatched_valid,
	output logic [sjf_pkg::ID_PORT_W-1:0]   dispatched_id,
	output logic [sjf_pkg::SUM_W-1:0]       total_turnaround,
	output logic [sjf_pkg::DONE_W-1:0]      completed_count,
	output logic                            server_busy,
	output logic [sjf_pkg::QCNT_OUT_W-1:0]  queue_count
);

	logic          cmd_valid;
	sjf_pkg::cmd_t cmd;
	logic          cmd_pop;

	sjf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.job_id    (job_id),
		.duration  (duration),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	sjf_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd              (cmd),
		.cmd_pop          (cmd_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.arrival_dropped  (arrival_dropped),
		.completed_valid  (completed_valid),
		.completed_id     (completed_id),
		.turnaround       (turnaround),
		.dispatched_valid (dispatched_valid),
		.dispatched_id    (dispatched_id),
		.total_turnaround (total_turnaround),
		.completed_count  (completed_count),
		.server_busy      (server_busy),
		.queue_count      (queue_count)
	);

endmodule

@@ hdl/sjf_front.sv @@
// front end: accepts and classifies items into a short command queue
module sjf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sjf_pkg::OP_W-1:0]       op,
	input  logic [sjf_pkg::ID_PORT_W-1:0]  job_id,
	input  logic [sjf_pkg::DUR_W-1:0]      duration,
	output logic                           cmd_valid,
	output sjf_pkg::cmd_t                  cmd,
	input  logic                           cmd_pop
);

	sjf_pkg::cmd_t                 fifo_q [sjf_pkg::FIFO_DEPTH];
	logic [sjf_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [sjf_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [sjf_pkg::FIFO_CW-1:0]   cnt_q;
	sjf_pkg::cmd_t                 new_cmd;
	logic                          push;
	logic                          pop;

	function automatic logic [sjf_pkg::FIFO_AW-1:0] ptr_inc(input logic [sjf_pkg::FIFO_AW-1:0] p);
		logic [sjf_pkg::FIFO_AW-1:0] r;
		if (p == sjf_pkg::FIFO_AW'(sjf_pkg::FIFO_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	// zero duration is served as one tick
	always_comb begin
		new_cmd.tick = (op == sjf_pkg::OP_TICK);
		new_cmd.id   = sjf_pkg::ID_BITS'(job_id);
		new_cmd.dur  = (duration == '0) ? sjf_pkg::DUR_W'(1) : duration;
	end

	assign in_stall  = (cnt_q == sjf_pkg::FIFO_CW'(sjf_pkg::FIFO_DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

@@ hdl/sjf_back.sv @@
// back end: wait slots, server state, shortest-job scan and result register
module sjf_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  sjf_pkg::cmd_t                   cmd,
	output logic                            cmd_pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            arrival_dropped,
	output logic                            completed_valid,
	output logic [sjf_pkg::ID_PORT_W-1:0]   completed_id,
	output logic [sjf_pkg::TIME_W-1:0]      turnaround,
	output logic                            dispatched_valid,
	output logic [sjf_pkg::ID_PORT_W-1:0]   dispatched_id,
	output logic [sjf_pkg::SUM_W-1:0]       total_turnaround,
	output logic [sjf_pkg::DONE_W-1:0]      completed_count,
	output logic                            server_busy,
	output logic [sjf_pkg::QCNT_OUT_W-1:0]  queue_count
);

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t                          state_q;
	logic                            out_valid_q;
	logic [sjf_pkg::QUEUE_DEPTH-1:0] wait_valid_q;
	sjf_pkg::key_t                   wait_key_q [sjf_pkg::QUEUE_DEPTH];
	logic [sjf_pkg::QCNT_W-1:0]      qcnt_q;
	logic [sjf_pkg::TIME_W-1:0]      now_q;
	logic                            busy_q;
	logic [sjf_pkg::ID_BITS-1:0]     run_id_q;
	logic [sjf_pkg::TIME_W-1:0]      run_arr_q;
	logic [sjf_pkg::TIME_W-1:0]      run_fin_q;
	logic [sjf_pkg::SUM_W-1:0]       sum_q;
	logic [sjf_pkg::DONE_W-1:0]      done_cnt_q;
	logic [sjf_pkg::QIDX_W-1:0]      idx_q;
	logic                            found_q;
	sjf_pkg::key_t                   best_key_q;
	logic [sjf_pkg::QIDX_W-1:0]      best_idx_q;
	logic                            dropped_q;
	logic                            cvalid_q;
	logic [sjf_pkg::ID_BITS-1:0]     cid_q;
	logic [sjf_pkg::TIME_W-1:0]      tat_q;
	logic                            dvalid_q;
	logic [sjf_pkg::ID_BITS-1:0]     did_q;

	logic                            out_free;
	logic                            pop;
	logic                            q_full;
	logic [sjf_pkg::QIDX_W-1:0]      free_idx;
	logic                            done_c;
	logic [sjf_pkg::TIME_W-1:0]      tat_c;
	logic [sjf_pkg::SUM_W:0]         sum_add;
	logic [sjf_pkg::SUM_W-1:0]       sum_next;
	sjf_pkg::key_t                   cand_key;
	logic                            take;
	sjf_pkg::key_t                   nb_key;
	logic [sjf_pkg::QIDX_W-1:0]      nb_idx;
	logic                            scan_last;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == ST_IDLE) && cmd_valid && out_free;
	assign cmd_pop  = pop;
	assign q_full   = (qcnt_q == sjf_pkg::QCNT_W'(sjf_pkg::QUEUE_DEPTH));

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = sjf_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!wait_valid_q[i]) begin
				free_idx = sjf_pkg::QIDX_W'(i);
			end
		end
	end

	assign done_c   = busy_q && (run_fin_q == now_q);
	assign tat_c    = run_fin_q - run_arr_q;
	assign sum_add  = {1'b0, sum_q} + (sjf_pkg::SUM_W + 1)'(tat_c);
	assign sum_next = sum_add[sjf_pkg::SUM_W] ? '1 : sum_add[sjf_pkg::SUM_W-1:0];

	// one slot per cycle, strict compare keeps the lower slot on full ties
	assign cand_key  = wait_key_q[idx_q];
	assign take      = wait_valid_q[idx_q] && (!found_q || (cand_key < best_key_q));
	assign nb_key    = take ? cand_key : best_key_q;
	assign nb_idx    = take ? idx_q : best_idx_q;
	assign scan_last = (idx_q == sjf_pkg::QIDX_W'(sjf_pkg::QUEUE_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			wait_valid_q <= '0;
			qcnt_q       <= '0;
			now_q        <= '0;
			busy_q       <= 1'b0;
			run_id_q     <= '0;
			run_arr_q    <= '0;
			run_fin_q    <= '0;
			sum_q        <= '0;
			done_cnt_q   <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (!cmd.tick) begin
							if (!q_full) begin
								wait_valid_q[free_idx] <= 1'b1;
								qcnt_q <= qcnt_q + 1'b1;
							end
							out_valid_q <= 1'b1;
						end else begin
							if (done_c) begin
								sum_q  <= sum_next;
								busy_q <= 1'b0;
								if (done_cnt_q != '1) begin
									done_cnt_q <= done_cnt_q + 1'b1;
								end
							end
							if ((!busy_q || done_c) && (qcnt_q != '0)) begin
								state_q     <= ST_SCAN;
								idx_q       <= '0;
								found_q     <= 1'b0;
								out_valid_q <= 1'b0;
							end else begin
								now_q       <= now_q + 1'b1;
								out_valid_q <= 1'b1;
							end
						end
					end
				end
				ST_SCAN: begin
					found_q <= found_q || take;
					idx_q   <= idx_q + 1'b1;
					if (scan_last) begin
						busy_q               <= 1'b1;
						run_id_q             <= nb_key.id;
						run_arr_q            <= nb_key.arr;
						run_fin_q            <= now_q + sjf_pkg::TIME_W'(nb_key.dur);
						wait_valid_q[nb_idx] <= 1'b0;
						qcnt_q               <= qcnt_q - 1'b1;
						now_q                <= now_q + 1'b1;
						out_valid_q          <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !cmd.tick && !q_full) begin
			wait_key_q[free_idx] <= '{dur: cmd.dur, arr: now_q, id: cmd.id};
		end
		if (state_q == ST_SCAN && take) begin
			best_key_q <= cand_key;
			best_idx_q <= idx_q;
		end
		if (pop) begin
			dropped_q <= !cmd.tick && q_full;
			cvalid_q  <= cmd.tick && done_c;
			cid_q     <= (cmd.tick && done_c) ? run_id_q : '0;
			tat_q     <= (cmd.tick && done_c) ? tat_c : '0;
			dvalid_q  <= 1'b0;
			did_q     <= '0;
		end else if (state_q == ST_SCAN && scan_last) begin
			dvalid_q <= 1'b1;
			did_q    <= nb_key.id;
		end
	end

	assign out_valid        = out_valid_q;
	assign arrival_dropped  = dropped_q;
	assign completed_valid  = cvalid_q;
	assign completed_id     = sjf_pkg::ID_PORT_W'(cid_q);
	assign turnaround       = tat_q;
	assign dispatched_valid = dvalid_q;
	assign dispatched_id    = sjf_pkg::ID_PORT_W'(did_q);
	assign total_turnaround = sum_q;
	assign completed_count  = done_cnt_q;
	assign server_busy      = busy_q;
	assign queue_count      = sjf_pkg::QCNT_OUT_W'(qcnt_q);

	a_qcnt_matches: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q == sjf_pkg::QCNT_W'($countones(wait_valid_q)))
		else $error("wait count out of step with slot valid bits");

	a_scan_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !out_valid_q)
		else $error("result pending during slot scan");

	a_dispatch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dvalid_q) |-> busy_q)
		else $error("dispatch reported with idle server");

	a_scan_finds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_last) |-> (found_q || take))
		else $error("scan ended without a candidate");

endmodule
